[sv/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg
// Types and constants shared by the binary trie min-xor table.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  localparam int KEY_W      = 30;     // key field width
  localparam int SCNT_W     = 11;     // stored_count field width
  localparam int PTR_W      = 15;     // node pointer width
  localparam int FILL_W     = PTR_W + 1;
  localparam int NODE_DEPTH = 32768;  // node store size, root included
  localparam int CNT_W      = 17;     // per-node key count
  localparam int NEED_W     = 6;      // nodes an insert may need

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_CLEAR  = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_ABSENT = 2'd2;
  localparam logic [1:0] STAT_FULL   = 2'd3;

  typedef enum logic [2:0] {
    OP_CHK_INS,
    OP_CHK_DEL,
    OP_INSERT,
    OP_DELETE,
    OP_QUERY
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  // one child link: present flag, pointer into next level, keys below it
  typedef struct packed {
    logic             present;
    logic [PTR_W-1:0] ptr;
    logic [CNT_W-1:0] cnt;
  } child_t;

  typedef struct packed {
    child_t lo;
    child_t hi;
  } node_t;

  // walk token passed from level to level
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [PTR_W-1:0]  ptr;
    logic              exists;
    logic              ok;
    logic [NEED_W-1:0] need;
    logic [KEY_W-1:0]  found;
  } tok_t;

endpackage

`default_nettype wire

[sv/btmx_req_if.sv]
// ----------------------------------------------------------------------------
// btmx_req_if
// Request channel: operation kind and key.
// ----------------------------------------------------------------------------
`default_nettype none

interface btmx_req_if import btmx_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       kind;
  logic [KEY_W-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

`default_nettype wire

[sv/btmx_rsp_if.sv]
// ----------------------------------------------------------------------------
// btmx_rsp_if
// Result channel: found key, stored count and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface btmx_rsp_if import btmx_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  found_key;
  logic [SCNT_W-1:0] stored_count;
  logic [1:0]        status;

  modport source (output valid, found_key, stored_count, status, input ready);
  modport sink   (input valid, found_key, stored_count, status, output ready);
endinterface

`default_nettype wire

[sv/btmx_cell.sv]
// ----------------------------------------------------------------------------
// btmx_cell
// One trie level: node memory, fill count and the step of the walk.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_cell import btmx_pkg::*; #(
  parameter int BIT_POS = 0,
  parameter int ADDR_W  = 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              clear,
  input  wire tok_t              tok_in,
  input  wire logic [FILL_W-1:0] next_fill,
  output tok_t                   tok_out,
  output logic [FILL_W-1:0]      fill,
  output logic                   alloc
);

  localparam logic [KEY_W-1:0] BIT_MASK = KEY_W'(1) << BIT_POS;

  node_t             mem [2**ADDR_W];
  node_t             rd;
  tok_t              tok;
  node_t             e;
  node_t             wentry;
  child_t            ch;
  child_t            nch;
  logic              hit;
  logic              kb;
  logic              use_b;
  logic              wr;
  logic              alloc_c;

  always_ff @(posedge clk) begin
    rd <= mem[tok_in.ptr[ADDR_W-1:0]];
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_in;
    end
  end

  assign hit = ({1'b0, tok.ptr} < fill);
  assign kb  = |(tok.key & BIT_MASK);

  always_comb begin
    e       = hit ? rd : '0;
    ch      = kb ? e.hi : e.lo;
    use_b   = kb;
    if (tok.op == OP_QUERY && !(ch.present && ch.cnt != '0)) begin
      use_b = ~kb;
      ch    = use_b ? e.hi : e.lo;
    end
    nch     = ch;
    tok_out = tok;
    wr      = 1'b0;
    alloc_c = 1'b0;
    case (tok.op)
      OP_CHK_INS: begin
        if (tok.exists && ch.present) begin
          tok_out.ptr = ch.ptr;
        end else begin
          tok_out.exists = 1'b0;
          tok_out.need   = tok.need + NEED_W'(1);
        end
      end
      OP_CHK_DEL: begin
        tok_out.ok  = tok.ok && ch.present && (ch.cnt != '0);
        tok_out.ptr = ch.ptr;
      end
      OP_INSERT: begin
        if (!ch.present) begin
          nch.present = 1'b1;
          nch.ptr     = next_fill[PTR_W-1:0];
          alloc_c     = 1'b1;
        end
        nch.cnt     = ch.cnt + CNT_W'(1);
        wr          = 1'b1;
        tok_out.ptr = nch.ptr;
      end
      OP_DELETE: begin
        nch.cnt     = ch.cnt - CNT_W'(1);
        wr          = 1'b1;
        tok_out.ptr = ch.ptr;
      end
      OP_QUERY: begin
        tok_out.found = use_b ? (tok.found | BIT_MASK) : tok.found;
        tok_out.ptr   = ch.ptr;
      end
      default: begin
        tok_out.ptr = ch.ptr;
      end
    endcase
    wentry = e;
    if (use_b) begin
      wentry.hi = nch;
    end else begin
      wentry.lo = nch;
    end
  end

  assign alloc = tok.valid && alloc_c;

  always_ff @(posedge clk) begin
    if (tok.valid && wr) begin
      mem[tok.ptr[ADDR_W-1:0]] <= wentry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      fill <= '0;
    end else if (tok.valid && wr && ({1'b0, tok.ptr} == fill)) begin
      fill <= fill + FILL_W'(1);
    end
  end

endmodule

`default_nettype wire

[sv/binary_trie_min_xor_table.sv]
// ----------------------------------------------------------------------------
// binary_trie_min_xor_table
// Multiset of keys in a binary trie with per-child counts; insert, delete,
// min-xor query and clear, one result item per request item.
// ----------------------------------------------------------------------------
// Sequence: a query, a rejected delete and a full insert make one walk; an
// insert or delete makes a check walk then an update walk, one trie level per
// cycle. Clear and early rejects skip the walk. The result register then
// loads once it is free.
// Flow: one item at a time; the next item is accepted the cycle after the
// result register loads.
// Reset: synchronous rst empties the store at once (fill counts cleared).
`default_nettype none

module binary_trie_min_xor_table import btmx_pkg::*; #(
  parameter int KEY_BITS    = 30,
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic clk,
  input  wire logic rst,
  btmx_req_if.sink   req,
  btmx_rsp_if.source rsp
);

  // Level j holds the nodes at depth j and branches on key bit KEY_BITS-1-j.
  // Each node stores both child links with the key count below each child,
  // so the root's own count sits in root_count and leaves need no storage.
  // Entries past a level's fill count read as empty: no clearing pass.

  state_t           state;
  state_t           state_next;
  logic [CNT_W-1:0] root_count;
  logic [PTR_W-1:0] alloc_total;     // nodes allocated besides the root
  logic [KEY_W-1:0] res_found;
  logic [1:0]       res_status;

  tok_t              link  [KEY_BITS+1];
  logic [FILL_W-1:0] fills [KEY_BITS];
  logic [KEY_BITS-1:0] allocs;

  tok_t             launch;
  tok_t             exit_tok;
  logic             clear_all;
  logic             root_inc;
  logic             root_dec;
  logic             set_res;
  logic [KEY_W-1:0] set_found;
  logic [1:0]       set_status;
  logic             load_rsp;
  logic             ins_full;
  logic             at_max;

  // walk chain
  assign link[0]  = launch;
  assign exit_tok = link[KEY_BITS];

  for (genvar j = 0; j < KEY_BITS; j++) begin : g_level
    localparam int AW = (j == 0) ? 1 : ((j < PTR_W) ? j : PTR_W);
    logic [FILL_W-1:0] nf;
    if (j < KEY_BITS - 1) begin : g_mid
      assign nf = fills[j+1];
    end else begin : g_leaf
      assign nf = '0;    // leaves are counted in their parent only
    end
    btmx_cell #(
      .BIT_POS (KEY_BITS - 1 - j),
      .ADDR_W  (AW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (clear_all),
      .tok_in    (link[j]),
      .next_fill (nf),
      .tok_out   (link[j+1]),
      .fill      (fills[j]),
      .alloc     (allocs[j])
    );
  end

  assign at_max   = (root_count >= CNT_W'(MAX_ENTRIES));
  // next free node plus the nodes needed must stay inside the store
  assign ins_full = (({1'b0, alloc_total} + FILL_W'(exit_tok.need))
                     > FILL_W'(NODE_DEPTH - 1));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          case (req.kind)
            KIND_INSERT: state_next = at_max ? ST_FINISH : ST_CHECK;
            KIND_DELETE: state_next = ST_CHECK;
            KIND_QUERY:  state_next = (root_count == '0) ? ST_FINISH : ST_UPDATE;
            default:     state_next = ST_FINISH;
          endcase
        end
      end
      ST_CHECK: begin
        if (exit_tok.valid) begin
          if (exit_tok.op == OP_CHK_INS) begin
            state_next = ins_full ? ST_FINISH : ST_UPDATE;
          end else begin
            state_next = exit_tok.ok ? ST_UPDATE : ST_FINISH;
          end
        end
      end
      ST_UPDATE: begin
        if (exit_tok.valid) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!rsp.valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    req.ready  = 1'b0;
    launch     = '0;
    launch.ptr = '0;
    clear_all  = 1'b0;
    root_inc   = 1'b0;
    root_dec   = 1'b0;
    set_res    = 1'b0;
    set_found  = '0;
    set_status = STAT_OK;
    load_rsp   = 1'b0;
    case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          launch.key    = req.key;
          launch.exists = 1'b1;
          launch.ok     = 1'b1;
          case (req.kind)
            KIND_INSERT: begin
              if (at_max) begin
                set_res    = 1'b1;
                set_status = STAT_FULL;
              end else begin
                launch.valid = 1'b1;
                launch.op    = OP_CHK_INS;
              end
            end
            KIND_DELETE: begin
              launch.valid = 1'b1;
              launch.op    = OP_CHK_DEL;
            end
            KIND_QUERY: begin
              if (root_count == '0) begin
                set_res    = 1'b1;
                set_status = STAT_EMPTY;
              end else begin
                launch.valid = 1'b1;
                launch.op    = OP_QUERY;
              end
            end
            default: begin
              clear_all = 1'b1;
              set_res   = 1'b1;
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (exit_tok.valid) begin
          launch.key    = exit_tok.key;
          launch.exists = 1'b1;
          launch.ok     = 1'b1;
          if (exit_tok.op == OP_CHK_INS) begin
            if (ins_full) begin
              set_res    = 1'b1;
              set_status = STAT_FULL;
            end else begin
              launch.valid = 1'b1;
              launch.op    = OP_INSERT;
              root_inc     = 1'b1;
            end
          end else begin
            if (!exit_tok.ok) begin
              set_res    = 1'b1;
              set_status = STAT_ABSENT;
            end else begin
              launch.valid = 1'b1;
              launch.op    = OP_DELETE;
              root_dec     = 1'b1;
            end
          end
        end
      end
      ST_UPDATE: begin
        if (exit_tok.valid) begin
          set_res   = 1'b1;
          set_found = (exit_tok.op == OP_QUERY) ? exit_tok.found : '0;
        end
      end
      ST_FINISH: begin
        load_rsp = !rsp.valid || rsp.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // store totals
  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      root_count  <= '0;
      alloc_total <= '0;
    end else begin
      if (root_inc) begin
        root_count <= root_count + CNT_W'(1);
      end else if (root_dec) begin
        root_count <= root_count - CNT_W'(1);
      end
      if (|allocs) begin
        alloc_total <= alloc_total + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_res) begin
      res_found  <= set_found;
      res_status <= set_status;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.found_key    <= res_found;
      rsp.stored_count <= root_count[SCNT_W-1:0];
      rsp.status       <= res_status;
    end
  end

endmodule

`default_nettype wire
